[sv/i2cee_pkg.sv]
// shared types and constants for the i2c eeprom byte master
// depends on nothing; used by the interfaces, the step logic and the top level
package i2cee_pkg;

  // command codes carried by an input beat
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_ACK_TIMEOUT    = 2'd1;
  localparam logic [1:0] REG_GAP_TICKS      = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // configuration reset values
  localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'd80;
  localparam logic [7:0]  ACK_TIMEOUT_RST    = 8'd255;
  localparam logic [15:0] GAP_TICKS_RST      = 16'd1600;

  // bit count at which a byte is complete
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // bus sequence stages
  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_GAP    = 4'd1,
    ST_START  = 4'd2,
    ST_DEVW   = 4'd3,
    ST_MEM    = 4'd4,
    ST_DATA   = 4'd5,
    ST_RSTART = 4'd6,
    ST_DEVR   = 4'd7,
    ST_READ   = 4'd8,
    ST_STOP   = 4'd9
  } stage_t;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [7:0]  ack_timeout_ticks;
    logic [15:0] gap_ticks;
  } cfg_t;

  typedef struct packed {
    stage_t      stage;
    logic [3:0]  phase;
    logic [3:0]  bit_count;
    logic [7:0]  tx_shift;
    logic [7:0]  rx_shift;
    logic        op_is_read;
    logic [7:0]  held_address;
    logic [7:0]  held_data;
    logic [15:0] wait_count;
    logic        clock_drive;
    logic        data_drive;
    logic        ack_fail;
  } seq_state_t;

  // per-beat flags from the step logic
  typedef struct packed {
    logic done;
    logic rejected;
  } step_flags_t;

endpackage

[sv/i2cee_if.sv]
// channel interfaces: request/tick input, result output, config write
// depends on i2cee_pkg for the config port widths
interface i2cee_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] mem_address;
  logic [7:0] write_data;
  logic       line_sense;
  modport source (output valid, cmd, mem_address, write_data, line_sense, input ready);
  modport sink (input valid, cmd, mem_address, write_data, line_sense, output ready);
endinterface

interface i2cee_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_missing;
  logic       rejected;
  modport source (output valid, scl_level, sda_level, busy_res, done_res, read_data,
                  ack_missing, rejected, input ready);
  modport sink (input valid, scl_level, sda_level, busy_res, done_res, read_data,
                ack_missing, rejected, output ready);
endinterface

interface i2cee_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [i2cee_pkg::CFG_INDEX_W-1:0] index;
  logic [i2cee_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/i2cee_step.sv]
// one phase of the bus sequence: next sequencer state from current state and a beat
// depends on i2cee_pkg for the state, config and flag types
module i2cee_step (
  input  i2cee_pkg::seq_state_t  state,
  input  i2cee_pkg::cfg_t        cfg,
  input  logic [1:0]             cmd,
  input  logic [7:0]             mem_address,
  input  logic [7:0]             write_data,
  input  logic                   line_sense,
  output i2cee_pkg::seq_state_t  state_nxt,
  output i2cee_pkg::step_flags_t flags
);

  logic busy;
  logic is_tick;
  logic is_req;
  logic gap_over;
  logic ack_end;
  logic [3:0] bit_inc;
  i2cee_pkg::stage_t stage_nxt;
  logic [3:0] phase_nxt;
  logic done_nxt;

  assign busy     = (state.stage != i2cee_pkg::ST_IDLE) || (state.phase != 4'd0);
  assign is_tick  = (cmd == i2cee_pkg::CMD_TICK) && busy;
  assign is_req   = (cmd == i2cee_pkg::CMD_WRITE) || (cmd == i2cee_pkg::CMD_READ);
  assign gap_over = state.wait_count >= cfg.gap_ticks;
  assign ack_end  = !line_sense || (state.wait_count >= {8'd0, cfg.ack_timeout_ticks});
  assign bit_inc  = state.bit_count + 4'd1;

  // stage and phase sequencing
  always_comb begin
    stage_nxt = state.stage;
    phase_nxt = state.phase;
    done_nxt  = 1'b0;
    if (is_req && !busy) begin
      stage_nxt = i2cee_pkg::ST_GAP;
      phase_nxt = 4'd0;
    end else if (is_tick) begin
      case (state.stage)
        i2cee_pkg::ST_GAP: begin
          if (gap_over) stage_nxt = i2cee_pkg::ST_START;
        end
        i2cee_pkg::ST_START, i2cee_pkg::ST_RSTART: begin
          if (state.phase == 4'd0 || state.phase == 4'd1) begin
            phase_nxt = state.phase + 4'd1;
          end else begin
            stage_nxt = (state.stage == i2cee_pkg::ST_RSTART) ?
                        i2cee_pkg::ST_DEVR : i2cee_pkg::ST_DEVW;
            phase_nxt = 4'd0;
          end
        end
        i2cee_pkg::ST_DEVW, i2cee_pkg::ST_MEM, i2cee_pkg::ST_DATA, i2cee_pkg::ST_DEVR: begin
          case (state.phase)
            4'd0, 4'd1, 4'd3, 4'd4, 4'd5: phase_nxt = state.phase + 4'd1;
            4'd2: phase_nxt = (bit_inc >= i2cee_pkg::BITS_PER_BYTE) ? 4'd3 : 4'd0;
            4'd6: begin
              if (ack_end) begin
                phase_nxt = 4'd0;
                case (state.stage)
                  i2cee_pkg::ST_DEVW: stage_nxt = i2cee_pkg::ST_MEM;
                  i2cee_pkg::ST_MEM: stage_nxt = state.op_is_read ?
                                       i2cee_pkg::ST_RSTART : i2cee_pkg::ST_DATA;
                  i2cee_pkg::ST_DATA: stage_nxt = i2cee_pkg::ST_STOP;
                  default: stage_nxt = i2cee_pkg::ST_READ;
                endcase
              end
            end
            default: begin
              stage_nxt = i2cee_pkg::ST_IDLE;
              phase_nxt = 4'd0;
            end
          endcase
        end
        i2cee_pkg::ST_READ: begin
          case (state.phase)
            4'd0, 4'd1, 4'd2, 4'd4: phase_nxt = state.phase + 4'd1;
            4'd3: phase_nxt = (bit_inc >= i2cee_pkg::BITS_PER_BYTE) ? 4'd4 : 4'd2;
            4'd5: begin
              stage_nxt = i2cee_pkg::ST_STOP;
              phase_nxt = 4'd0;
            end
            default: begin
              stage_nxt = i2cee_pkg::ST_IDLE;
              phase_nxt = 4'd0;
            end
          endcase
        end
        i2cee_pkg::ST_STOP: begin
          if (state.phase == 4'd0 || state.phase == 4'd1) begin
            phase_nxt = state.phase + 4'd1;
          end else begin
            stage_nxt = i2cee_pkg::ST_IDLE;
            phase_nxt = 4'd0;
            done_nxt  = 1'b1;
          end
        end
        default: begin
          stage_nxt = i2cee_pkg::ST_IDLE;
          phase_nxt = 4'd0;
        end
      endcase
    end
  end

  // line drives, shift registers, counters and flags
  always_comb begin
    state_nxt.stage        = stage_nxt;
    state_nxt.phase        = phase_nxt;
    state_nxt.bit_count    = state.bit_count;
    state_nxt.tx_shift     = state.tx_shift;
    state_nxt.rx_shift     = state.rx_shift;
    state_nxt.op_is_read   = state.op_is_read;
    state_nxt.held_address = state.held_address;
    state_nxt.held_data    = state.held_data;
    state_nxt.wait_count   = state.wait_count;
    state_nxt.clock_drive  = state.clock_drive;
    state_nxt.data_drive   = state.data_drive;
    state_nxt.ack_fail     = state.ack_fail;
    flags.done             = done_nxt;
    flags.rejected         = is_req && busy;
    if (is_req && !busy) begin
      state_nxt.op_is_read   = (cmd == i2cee_pkg::CMD_READ);
      state_nxt.held_address = mem_address;
      state_nxt.held_data    = write_data;
      state_nxt.ack_fail     = 1'b0;
      state_nxt.wait_count   = 16'd0;
      state_nxt.bit_count    = 4'd0;
    end else if (is_tick) begin
      case (state.stage)
        i2cee_pkg::ST_GAP: begin
          if (!gap_over) state_nxt.wait_count = state.wait_count + 16'd1;
        end
        i2cee_pkg::ST_START, i2cee_pkg::ST_RSTART: begin
          if (state.phase == 4'd0) begin
            state_nxt.data_drive = 1'b1;
          end else if (state.phase == 4'd1) begin
            state_nxt.clock_drive = 1'b1;
          end else begin
            state_nxt.data_drive = 1'b0;
            state_nxt.bit_count  = 4'd0;
            state_nxt.tx_shift   = {cfg.device_address,
                                    state.stage == i2cee_pkg::ST_RSTART};
          end
        end
        i2cee_pkg::ST_DEVW, i2cee_pkg::ST_MEM, i2cee_pkg::ST_DATA, i2cee_pkg::ST_DEVR: begin
          case (state.phase)
            4'd0, 4'd3: state_nxt.clock_drive = 1'b0;
            4'd1: begin
              state_nxt.data_drive = state.tx_shift[7];
              state_nxt.tx_shift   = {state.tx_shift[6:0], 1'b0};
            end
            4'd2: begin
              state_nxt.clock_drive = 1'b1;
              state_nxt.bit_count   = bit_inc;
            end
            4'd4: state_nxt.data_drive = 1'b1;
            4'd5: begin
              state_nxt.clock_drive = 1'b1;
              state_nxt.wait_count  = 16'd0;
            end
            4'd6: begin
              if (ack_end) begin
                // a high line here means the slave never acked
                if (line_sense) state_nxt.ack_fail = 1'b1;
                state_nxt.clock_drive = 1'b0;
                state_nxt.bit_count   = 4'd0;
                if (state.stage == i2cee_pkg::ST_DEVW) begin
                  state_nxt.tx_shift = state.held_address;
                end else if (state.stage == i2cee_pkg::ST_MEM && !state.op_is_read) begin
                  state_nxt.tx_shift = state.held_data;
                end
              end else begin
                state_nxt.wait_count = state.wait_count + 16'd1;
              end
            end
            default: begin
              state_nxt.clock_drive = 1'b1;
              state_nxt.data_drive  = 1'b1;
            end
          endcase
        end
        i2cee_pkg::ST_READ: begin
          case (state.phase)
            4'd0: state_nxt.clock_drive = 1'b0;
            4'd1: begin
              state_nxt.data_drive = 1'b1;
              state_nxt.bit_count  = 4'd0;
              state_nxt.tx_shift   = 8'd0;
            end
            4'd2: state_nxt.clock_drive = 1'b1;
            4'd3: begin
              state_nxt.tx_shift    = {state.tx_shift[6:0], line_sense};
              state_nxt.clock_drive = 1'b0;
              state_nxt.bit_count   = bit_inc;
            end
            // master nack clock pulse
            4'd4: begin
              state_nxt.data_drive  = 1'b1;
              state_nxt.clock_drive = 1'b1;
            end
            4'd5: begin
              state_nxt.clock_drive = 1'b0;
              state_nxt.rx_shift    = state.tx_shift;
            end
            default: begin
              state_nxt.clock_drive = 1'b1;
              state_nxt.data_drive  = 1'b1;
            end
          endcase
        end
        i2cee_pkg::ST_STOP: begin
          if (state.phase == 4'd0) begin
            state_nxt.data_drive = 1'b0;
          end else if (state.phase == 4'd1) begin
            state_nxt.clock_drive = 1'b1;
          end else begin
            state_nxt.data_drive = 1'b1;
          end
        end
        default: begin
          state_nxt.clock_drive = 1'b1;
          state_nxt.data_drive  = 1'b1;
        end
      endcase
    end
  end

endmodule

[sv/i2c_eeprom_byte_master.sv]
// top level of the i2c eeprom byte master: config registers, sequencer state, result register
// depends on i2cee_pkg, the channel interfaces and i2cee_step
//
// Usage:
//   in_ch carries one beat per command: a tick (advance the bus by one phase),
//   a write request or a read request with the memory address and write byte.
//   Every accepted input beat produces exactly one result beat on out_ch with
//   the line drives, busy, done, the last read byte, the missing-ack flag and
//   whether a request was dropped because a transaction was already running.
//   cfg_ch writes device address, ack timeout and gap length; it is always
//   ready and should only be written while no transaction is running.
//   Result: registered; it appears in the cycle after its input beat is accepted.
//   Throughput: one beat per cycle while out_ch is not stalled; the sequencer
//   state register closes the loop from one beat to the next.
//   Stall: when out_ch is not taken, the result register holds and in_ch
//   drops ready; input is taken again in the cycle the result leaves.
//   Reset (rst_n low, synchronous): lines released, sequencer idle, flags
//   cleared, config back to address 80, timeout 255, gap 1600.
module i2c_eeprom_byte_master (
  input  logic                 clk,
  input  logic                 rst_n,
  i2cee_in_if.sink             in_ch,
  i2cee_out_if.source          out_ch,
  i2cee_cfg_if.sink            cfg_ch
);

  i2cee_pkg::cfg_t        cfg_r;
  i2cee_pkg::seq_state_t  state_r;
  i2cee_pkg::seq_state_t  state_nxt;
  i2cee_pkg::step_flags_t flags;
  logic                   out_valid_r;
  logic                   in_beat;
  logic                   scl_r;
  logic                   sda_r;
  logic                   busy_r;
  logic                   done_r;
  logic [7:0]             read_data_r;
  logic                   ack_missing_r;
  logic                   rejected_r;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_beat      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  i2cee_step u_step (
    .state       (state_r),
    .cfg         (cfg_r),
    .cmd         (in_ch.cmd),
    .mem_address (in_ch.mem_address),
    .write_data  (in_ch.write_data),
    .line_sense  (in_ch.line_sense),
    .state_nxt   (state_nxt),
    .flags       (flags)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address    <= i2cee_pkg::DEVICE_ADDRESS_RST;
      cfg_r.ack_timeout_ticks <= i2cee_pkg::ACK_TIMEOUT_RST;
      cfg_r.gap_ticks         <= i2cee_pkg::GAP_TICKS_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        i2cee_pkg::REG_DEVICE_ADDRESS: cfg_r.device_address <= cfg_ch.data[6:0];
        i2cee_pkg::REG_ACK_TIMEOUT:    cfg_r.ack_timeout_ticks <= cfg_ch.data[7:0];
        i2cee_pkg::REG_GAP_TICKS:      cfg_r.gap_ticks <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{stage: i2cee_pkg::ST_IDLE, phase: 4'd0, bit_count: 4'd0,
                   tx_shift: 8'd0, rx_shift: 8'd0, op_is_read: 1'b0,
                   held_address: 8'd0, held_data: 8'd0, wait_count: 16'd0,
                   clock_drive: 1'b1, data_drive: 1'b1, ack_fail: 1'b0};
    end else if (in_beat) begin
      state_r <= state_nxt;
    end
  end

  // result beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      scl_r         <= state_nxt.clock_drive;
      sda_r         <= state_nxt.data_drive;
      busy_r        <= (state_nxt.stage != i2cee_pkg::ST_IDLE) || (state_nxt.phase != 4'd0);
      done_r        <= flags.done;
      read_data_r   <= state_nxt.rx_shift;
      ack_missing_r <= state_nxt.ack_fail;
      rejected_r    <= flags.rejected;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.scl_level   = scl_r;
  assign out_ch.sda_level   = sda_r;
  assign out_ch.busy_res    = busy_r;
  assign out_ch.done_res    = done_r;
  assign out_ch.read_data   = read_data_r;
  assign out_ch.ack_missing = ack_missing_r;
  assign out_ch.rejected    = rejected_r;

endmodule

[sv/i2cee_checker.sv]
// port-level checks for i2c_eeprom_byte_master, and the bind that attaches them
// depends on the top level's clock, reset and channel ports only
module i2cee_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic scl_level,
  input logic sda_level,
  input logic busy_res,
  input logic done_res,
  input logic rejected
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a finished transaction leaves the bus idle and released
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> !busy_res && scl_level && sda_level && !rejected)
    else $error("done without idle released bus");

  // a dropped request only happens while a transaction runs
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && rejected |-> busy_res)
    else $error("request rejected while idle");

endmodule

bind i2c_eeprom_byte_master i2cee_checker u_i2cee_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .scl_level (out_ch.scl_level),
  .sda_level (out_ch.sda_level),
  .busy_res  (out_ch.busy_res),
  .done_res  (out_ch.done_res),
  .rejected  (out_ch.rejected)
);
